// ===== sv/indexed_min_heap_defines.svh =====
// Assertion macros for the indexed min-heap block
`ifndef INDEXED_MIN_HEAP_DEFINES_SVH
`define INDEXED_MIN_HEAP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define IMH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define IMH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/imh_pkg.sv =====
// Shared types and codes for the indexed min-heap
`default_nettype none
package imh_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_DUPLICATE = 2'd3
    } t_status;

    // Datapath commands issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,      // capture key, clear slot index
        DP_RD_IDX,    // read slot at index
        DP_IDX_INC,   // step search index
        DP_RD_PAR,    // read parent of index
        DP_MOVE_UP,   // write read word at index, index to parent
        DP_WR_KEY,    // write held key at index
        DP_SET_INS,   // index to size, size up by one
        DP_DEC,       // size down by one
        DP_RD_LAST,   // read slot at size
        DP_LAST_KEY,  // held key takes read word, index to root
        DP_RD_L,      // read left child
        DP_CAP_L,     // hold left child, read right child
        DP_CHOOSE,    // keep smaller child
        DP_MOVE_DN    // write child at index, index to child
    } t_dp_op;

    // Datapath flags back to the controller
    typedef struct packed {
        logic match;
        logic idx_lt_size;
        logic full;
        logic idx_zero;
        logic par_gt_key;
        logic left_lt_size;
        logic key_gt_child;
        logic size_zero;
    } t_dp_stat;

    localparam logic [31:0] EMPTY_MIN = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

// ===== sv/imh_in_if.sv =====
// Request channel: operation and value
`default_nettype none
interface imh_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] value;
    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface
`default_nettype wire

// ===== sv/imh_out_if.sv =====
// Result channel: status, minimum, empty flag and count
`default_nettype none
interface imh_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] minimum;
    logic        is_empty;
    logic [8:0]  entry_count;
    modport source (output valid, output status, output minimum, output is_empty,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input minimum, input is_empty,
                    input entry_count, output ready);
endinterface
`default_nettype wire

// ===== sv/indexed_min_heap.sv =====
// Indexed binary min-heap: insert and delete-by-value with one result word per request.
// A stored insert runs a linear slot search through the single RAM port, then sift-up; a
//   delete runs the same search, then force-to-root and sift-down.
// Throughput: one request at a time; a new word is taken once the result is taken.
// Reset: synchronous active-low i_rst_n empties the heap; RAM contents need no clearing.
`default_nettype none
`include "indexed_min_heap_defines.svh"
module indexed_min_heap #(
    parameter int CAPACITY = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    imh_in_if.sink    i_in,
    imh_out_if.source o_out
);
    import imh_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_dp_op        w_op;
    t_dp_stat      w_stat;
    t_status       w_status;
    logic [CW-1:0] w_size;
    logic [CW+8:0] w_size_ext;

    imh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_del   (i_in.operation),
        .o_in_ready (i_in.ready),
        .o_out_valid(o_out.valid),
        .i_out_ready(o_out.ready),
        .o_status   (w_status),
        .i_stat     (w_stat),
        .o_op       (w_op)
    );

    imh_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (w_op),
        .i_value  (i_in.value),
        .o_stat   (w_stat),
        .o_minimum(o_out.minimum),
        .o_size   (w_size)
    );

    // Result word
    assign w_size_ext        = {9'd0, w_size};
    assign o_out.status      = w_status;
    assign o_out.is_empty    = (w_size == '0);
    assign o_out.entry_count = w_size_ext[8:0];

    `IMH_ASSERT_NOW(a_one_word, i_in.ready, !o_out.valid, "request taken while result pending")
    `IMH_ASSERT_NOW(a_count_cap, 1'b1, w_size <= CW'(CAPACITY), "entry count above capacity")
    `IMH_ASSERT_NOW(a_full_cnt, o_out.valid && w_status == ST_FULL, w_size == CW'(CAPACITY),
        "full status below capacity")
    `IMH_ASSERT_NEXT(a_out_hold, o_out.valid && !o_out.ready, o_out.valid && $stable(w_size),
        "result dropped or count changed while stalled")
endmodule
`default_nettype wire

// ===== sv/imh_ram.sv =====
// Generic single-port RAM with registered read
`default_nettype none
module imh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== sv/imh_datapath.sv =====
// Heap datapath: slot index, held key, size, root copy and heap RAM
`default_nettype none
module imh_datapath #(
    parameter int CAPACITY = 256,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire imh_pkg::t_dp_op   i_op,
    input  wire logic [31:0]       i_value,
    output imh_pkg::t_dp_stat      o_stat,
    output logic [31:0]            o_minimum,
    output logic [CW-1:0]          o_size
);
    import imh_pkg::*;

    localparam int LW = CW + 1;

    logic [31:0]   r_key, r_child, r_root;
    logic [CW-1:0] r_idx;   // wide enough to step past the last slot of a full heap
    logic [AW-1:0] r_cidx;
    logic [CW-1:0] r_size;

    logic [AW-1:0] w_par;
    logic [LW-1:0] w_left, w_right, w_size_ext;
    logic          w_we;
    logic [AW-1:0] w_addr;
    logic [31:0]   w_wdata, w_rdata;

    // Tree index arithmetic
    assign w_par      = AW'((r_idx - CW'(1)) >> 1);
    assign w_left     = {r_idx, 1'b1};
    assign w_right    = w_left + LW'(1);
    assign w_size_ext = LW'(r_size);

    // RAM port select
    always_comb begin
        w_we    = 1'b0;
        w_addr  = AW'(r_idx);
        w_wdata = r_key;
        case (i_op)
            DP_RD_PAR:  w_addr = w_par;
            DP_MOVE_UP: begin
                w_we    = 1'b1;
                w_wdata = w_rdata;
            end
            DP_WR_KEY:  w_we = 1'b1;
            DP_RD_LAST: w_addr = AW'(r_size);
            DP_RD_L:    w_addr = AW'(w_left);
            DP_CAP_L:   w_addr = AW'(w_right);
            DP_MOVE_DN: begin
                w_we    = 1'b1;
                w_wdata = r_child;
            end
            default: ;
        endcase
    end

    imh_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    // Size counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
        end else if (i_op == DP_SET_INS) begin
            r_size <= r_size + CW'(1);
        end else if (i_op == DP_DEC) begin
            r_size <= r_size - CW'(1);
        end
    end

    // Index, key, child and root copy
    always_ff @(posedge i_clk) begin
        if (w_we && w_addr == '0) begin
            r_root <= w_wdata;
        end
        case (i_op)
            DP_LOAD: begin
                r_key <= i_value;
                r_idx <= '0;
            end
            DP_IDX_INC:  r_idx <= r_idx + CW'(1);
            DP_MOVE_UP:  r_idx <= CW'(w_par);
            DP_SET_INS:  r_idx <= r_size;
            DP_LAST_KEY: begin
                r_key <= w_rdata;
                r_idx <= '0;
            end
            DP_CAP_L: begin
                r_child <= w_rdata;
                r_cidx  <= AW'(w_left);
            end
            DP_CHOOSE: begin
                if (w_right < w_size_ext && $signed(r_child) > $signed(w_rdata)) begin
                    r_child <= w_rdata;
                    r_cidx  <= AW'(w_right);
                end
            end
            DP_MOVE_DN:  r_idx <= CW'(r_cidx);
            default: ;
        endcase
    end

    // Flags
    assign o_stat.match        = (w_rdata == r_key);
    assign o_stat.idx_lt_size  = (r_idx < r_size);
    assign o_stat.full         = (r_size >= CW'(CAPACITY));
    assign o_stat.idx_zero     = (r_idx == '0);
    assign o_stat.par_gt_key   = ($signed(w_rdata) > $signed(r_key));
    assign o_stat.left_lt_size = (w_left < w_size_ext);
    assign o_stat.key_gt_child = ($signed(r_key) > $signed(r_child));
    assign o_stat.size_zero    = (r_size == '0);

    assign o_minimum = (r_size == '0) ? EMPTY_MIN : r_root;
    assign o_size    = r_size;
endmodule
`default_nettype wire

// ===== sv/imh_ctrl.sv =====
// Heap controller: search, sift-up, force-to-root and sift-down sequencing
`default_nettype none
module imh_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_del,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output imh_pkg::t_status       o_status,
    input  wire imh_pkg::t_dp_stat i_stat,
    output imh_pkg::t_dp_op        o_op
);
    import imh_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_SRD    = 14'b00000000000010,
        S_SCMP   = 14'b00000000000100,
        S_UP_CHK = 14'b00000000001000,
        S_UP_CMP = 14'b00000000010000,
        S_DEL_UP = 14'b00000000100000,
        S_DEL_MV = 14'b00000001000000,
        S_POP    = 14'b00000010000000,
        S_POP_W  = 14'b00000100000000,
        S_DN_CHK = 14'b00001000000000,
        S_DN_L   = 14'b00010000000000,
        S_DN_R   = 14'b00100000000000,
        S_DN_CMP = 14'b01000000000000,
        S_RESP   = 14'b10000000000000
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    r_del, n_del;

    // Next state and datapath command
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_del    = r_del;
        o_op     = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = DP_LOAD;
                    n_del   = i_in_del;
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                if (i_stat.idx_lt_size) begin
                    o_op    = DP_RD_IDX;
                    n_state = S_SCMP;
                end else if (r_del) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else if (i_stat.full) begin
                    n_status = ST_FULL;
                    n_state  = S_RESP;
                end else begin
                    o_op    = DP_SET_INS;
                    n_state = S_UP_CHK;
                end
            end
            S_SCMP: begin
                if (!i_stat.match) begin
                    o_op    = DP_IDX_INC;
                    n_state = S_SRD;
                end else if (r_del) begin
                    n_state = S_DEL_UP;
                end else begin
                    n_status = ST_DUPLICATE;
                    n_state  = S_RESP;
                end
            end
            S_UP_CHK: begin
                if (i_stat.idx_zero) begin
                    o_op     = DP_WR_KEY;
                    n_status = ST_OK;
                    n_state  = S_RESP;
                end else begin
                    o_op    = DP_RD_PAR;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_stat.par_gt_key) begin
                    o_op    = DP_MOVE_UP;
                    n_state = S_UP_CHK;
                end else begin
                    o_op     = DP_WR_KEY;
                    n_status = ST_OK;
                    n_state  = S_RESP;
                end
            end
            S_DEL_UP: begin
                if (i_stat.idx_zero) begin
                    o_op    = DP_DEC;
                    n_state = S_POP;
                end else begin
                    o_op    = DP_RD_PAR;
                    n_state = S_DEL_MV;
                end
            end
            S_DEL_MV: begin
                o_op    = DP_MOVE_UP;
                n_state = S_DEL_UP;
            end
            S_POP: begin
                n_status = ST_OK;
                if (i_stat.size_zero) begin
                    n_state = S_RESP;
                end else begin
                    o_op    = DP_RD_LAST;
                    n_state = S_POP_W;
                end
            end
            S_POP_W: begin
                o_op    = DP_LAST_KEY;
                n_state = S_DN_CHK;
            end
            S_DN_CHK: begin
                if (i_stat.left_lt_size) begin
                    o_op    = DP_RD_L;
                    n_state = S_DN_L;
                end else begin
                    o_op    = DP_WR_KEY;
                    n_state = S_RESP;
                end
            end
            S_DN_L: begin
                o_op    = DP_CAP_L;
                n_state = S_DN_R;
            end
            S_DN_R: begin
                o_op    = DP_CHOOSE;
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (i_stat.key_gt_child) begin
                    o_op    = DP_MOVE_DN;
                    n_state = S_DN_CHK;
                end else begin
                    o_op    = DP_WR_KEY;
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_status <= n_status;
        r_del    <= n_del;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_RESP);
    assign o_status    = r_status;
endmodule
`default_nettype wire
